@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Both forms take the clock and the
// active-low reset explicitly so that a check is off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define RSSG_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the first condition holds, the second holds in the next cycle.
`define RSSG_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define RSSG_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)

`define RSSG_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

@@ hdl/rssg_pkg.sv @@
package rssg_pkg;

    // Result status codes.
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_END = 2'd1;
    localparam logic [1:0] ST_ERR = 2'd2;

    // Request kinds.
    localparam logic [1:0] K_APPEND  = 2'd0;
    localparam logic [1:0] K_NEXT    = 2'd1;
    localparam logic [1:0] K_RESTART = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_FIRST = 1'b0;
    localparam logic CFG_LAST  = 1'b1;

    // Characters with a meaning of their own in the specifier.
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;

    localparam logic [6:0] NO_DIGIT = 7'd99;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEXT,
        S_SKIP,
        S_TOK,
        S_FIN,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        F_EMPTY,
        F_SIGN,
        F_ZERO,
        F_ZX,
        F_DIG,
        F_BAD
    } t_fstate;

    typedef struct packed {
        logic clr;
        logic feed;
    } t_fld_ctl;

    typedef struct packed {
        logic               empty;
        logic               good;
        logic signed [31:0] num;
    } t_fld_res;

    function automatic logic is_sep(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0b ||
               c == 8'h0c || c == 8'h0d || c == 8'h2c || c == 8'h00;
    endfunction

    function automatic logic [6:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            d = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h5a) begin
            d = c - 8'h37;
        end else begin
            d = {1'b0, NO_DIGIT};
        end
        return d[6:0];
    endfunction

endpackage

@@ hdl/range_spec_sequence_generator_unit.sv @@
//  Channel   Direction  Handshake           Payload
//  request   in         i_valid / o_ready   i_kind, i_char_in
//  result    out        o_valid / i_ready   o_status, o_value
//  config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
//  An append, a restart or an unused kind completes without leaving the idle state
//  and gives a registered result. A next request that the running range still
//  serves goes from S_NEXT straight to S_DONE; otherwise S_SKIP steps over
//  separators and S_TOK reads the token, since the spec memory gives one character
//  per cycle, and S_FIN closes it. With no token left the result is an end status,
//  and a token at the length limit ends in S_DONE with an error status. Reset is
//  synchronous; the spec memory is not cleared.
//  A stalled result holds in the output register; requests wait until it goes.
`include "assert_macros.svh"

module range_spec_sequence_generator_unit #(
    parameter int SPEC_CAPACITY = 256,
    parameter int TOKEN_LIMIT   = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_char_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic signed [31:0] o_value,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import rssg_pkg::*;

    localparam int LEN_W  = $clog2(SPEC_CAPACITY + 1);
    localparam int ADDR_W = $clog2(SPEC_CAPACITY);
    localparam int TL_W   = $clog2(TOKEN_LIMIT);

    // The stored specifier; read every cycle at the next scan pointer.
    logic [7:0] mem [SPEC_CAPACITY];
    logic [7:0] r_rdata;

    t_state r_state, n_state;

    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_scan, n_scan;
    logic [LEN_W-1:0] r_ptr, n_ptr;
    logic signed [31:0] r_cur, n_cur;
    logic signed [31:0] r_start, n_start;
    logic signed [31:0] r_end, n_end;
    logic signed [31:0] r_step, n_step;
    logic signed [31:0] r_first, r_last;

    // Token under construction: head, tail and step with their defaults.
    logic signed [31:0] r_t0, n_t0;
    logic signed [31:0] r_t1, n_t1;
    logic signed [31:0] r_t2, n_t2;
    logic [1:0]         r_cnt, n_cnt;
    logic               r_err, n_err;
    logic               r_colon, n_colon;
    logic [TL_W-1:0]    r_tlen, n_tlen;
    logic [1:0]         r_st, n_st;

    logic               r_ovalid, n_ovalid;
    logic [1:0]         r_ostatus, n_ostatus;
    logic signed [31:0] r_ovalue, n_ovalue;

    logic               in_fire;
    logic               out_free;
    logic               at_end;
    logic               ch_sep;
    logic               ch_colon;
    logic               tok_long;
    logic signed [31:0] sum;
    logic               step_hit;
    logic               range_empty;
    logic               append_ok;

    t_fld_ctl           fld_ctl;
    t_fld_res           fld_res;

    logic signed [31:0] fe_t0, fe_t1, fe_t2;
    logic               fe_err;

    rssg_num u_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fld_ctl),
        .i_char  (r_rdata),
        .o_res   (fld_res)
    );

    assign out_free  = !r_ovalid || i_ready;
    assign o_ready   = (r_state == S_IDLE) && out_free;
    assign in_fire   = i_valid && o_ready;
    assign append_ok = r_len < LEN_W'(SPEC_CAPACITY);
    assign at_end    = r_ptr >= r_len;
    assign ch_sep    = is_sep(r_rdata);
    assign ch_colon  = (r_rdata == CH_COLON);
    assign tok_long  = (r_tlen == TL_W'(TOKEN_LIMIT - 1));
    assign sum       = r_cur + r_step;

    // The running range yields another value while the wrapped sum stays
    // on the near side of the tail.
    assign step_hit = (r_step > 32'sd0 && sum <= r_end) ||
                      (r_step < 32'sd0 && sum >= r_end);

    assign range_empty = (r_t2 > 32'sd0 && r_t1 < r_t0) ||
                         (r_t2 < 32'sd0 && r_t1 > r_t0);

    // Closing a field stores its number in the slot it belongs to. An empty
    // field keeps the default, and anything that is not a whole number is
    // an error for the token.
    always_comb begin
        fe_t0  = r_t0;
        fe_t1  = r_t1;
        fe_t2  = r_t2;
        fe_err = r_err;
        if (fld_res.good) begin
            case (r_cnt)
                2'd0:    fe_t0 = fld_res.num;
                2'd1:    fe_t1 = fld_res.num;
                default: fe_t2 = fld_res.num;
            endcase
        end else if (!fld_res.empty) begin
            fe_err = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && i_kind == K_NEXT) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: n_state = step_hit ? S_DONE : S_SKIP;
            S_SKIP: begin
                if (at_end) begin
                    n_state = S_DONE;
                end else if (!ch_sep) begin
                    n_state = S_TOK;
                end
            end
            S_TOK: begin
                if (at_end || ch_sep) begin
                    n_state = S_FIN;
                end else if (tok_long) begin
                    n_state = S_DONE;
                end
            end
            S_FIN:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_len     = r_len;
        n_scan    = r_scan;
        n_ptr     = r_ptr;
        n_cur     = r_cur;
        n_start   = r_start;
        n_end     = r_end;
        n_step    = r_step;
        n_t0      = r_t0;
        n_t1      = r_t1;
        n_t2      = r_t2;
        n_cnt     = r_cnt;
        n_err     = r_err;
        n_colon   = r_colon;
        n_tlen    = r_tlen;
        n_st      = r_st;
        n_ovalid  = r_ovalid && !i_ready;
        n_ostatus = r_ostatus;
        n_ovalue  = r_ovalue;
        fld_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_kind)
                        K_APPEND: begin
                            n_ovalid = 1'b1;
                            n_ovalue = 32'sd0;
                            if (append_ok) begin
                                n_len     = r_len + 1'b1;
                                n_ostatus = ST_OK;
                            end else begin
                                n_ostatus = ST_ERR;
                            end
                        end
                        K_NEXT: begin
                            n_ptr = r_scan;
                        end
                        K_RESTART: begin
                            n_scan    = '0;
                            n_cur     = 32'sd0;
                            n_start   = 32'sd0;
                            n_end     = 32'sd0;
                            n_step    = 32'sd0;
                            n_ovalid  = 1'b1;
                            n_ostatus = ST_OK;
                            n_ovalue  = 32'sd0;
                        end
                        default: begin
                            n_ovalid  = 1'b1;
                            n_ostatus = ST_ERR;
                            n_ovalue  = 32'sd0;
                        end
                    endcase
                end
            end
            S_NEXT: begin
                if (step_hit) begin
                    n_cur = sum;
                    n_st  = ST_OK;
                end
            end
            S_SKIP: begin
                if (at_end) begin
                    n_st = ST_END;
                end else if (ch_sep) begin
                    n_ptr = r_ptr + 1'b1;
                end else begin
                    // First character of a token: it is taken in the next cycle.
                    fld_ctl.clr = 1'b1;
                    n_t0    = r_first;
                    n_t1    = r_last;
                    n_t2    = 32'sd1;
                    n_cnt   = 2'd0;
                    n_err   = 1'b0;
                    n_colon = 1'b0;
                    n_tlen  = '0;
                end
            end
            S_TOK: begin
                if (at_end || ch_sep) begin
                    if (r_cnt != 2'd3) begin
                        n_t0  = fe_t0;
                        n_t1  = fe_t1;
                        n_t2  = fe_t2;
                        n_err = fe_err;
                    end
                    n_scan = r_ptr;
                end else if (tok_long) begin
                    // The scan position stays, so the error repeats.
                    n_st = ST_ERR;
                end else begin
                    n_tlen = r_tlen + 1'b1;
                    n_ptr  = r_ptr + 1'b1;
                    if (ch_colon) begin
                        n_colon = 1'b1;
                        if (r_cnt != 2'd3) begin
                            n_t0        = fe_t0;
                            n_t1        = fe_t1;
                            n_t2        = fe_t2;
                            n_err       = fe_err;
                            n_cnt       = r_cnt + 1'b1;
                            fld_ctl.clr = 1'b1;
                        end
                    end else if (r_cnt != 2'd3) begin
                        fld_ctl.feed = 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (r_err) begin
                    n_st = ST_ERR;
                end else if (r_colon) begin
                    n_start = r_t0;
                    n_end   = r_t1;
                    n_step  = r_t2;
                    n_cur   = r_t0;
                    n_st    = range_empty ? ST_END : ST_OK;
                end else begin
                    n_step = 32'sd0;
                    n_cur  = r_t0;
                    n_st   = ST_OK;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_st;
                    n_ovalue  = r_cur;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_scan   <= '0;
            r_cur    <= 32'sd0;
            r_start  <= 32'sd0;
            r_end    <= 32'sd0;
            r_step   <= 32'sd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_scan   <= n_scan;
            r_cur    <= n_cur;
            r_start  <= n_start;
            r_end    <= n_end;
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
        end
        r_ptr     <= n_ptr;
        r_t0      <= n_t0;
        r_t1      <= n_t1;
        r_t2      <= n_t2;
        r_cnt     <= n_cnt;
        r_err     <= n_err;
        r_colon   <= n_colon;
        r_tlen    <= n_tlen;
        r_st      <= n_st;
        r_ostatus <= n_ostatus;
        r_ovalue  <= n_ovalue;
    end

    // Configuration registers hold the defaults for omitted fields.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 32'sd0;
            r_last  <= 32'sd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST: r_first <= i_cfg_data;
                CFG_LAST:  r_last  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Spec memory: one write port for appends, one registered read port.
    always_ff @(posedge i_clk) begin
        if (in_fire && i_kind == K_APPEND && append_ok) begin
            mem[r_len[ADDR_W-1:0]] <= i_char_in;
        end
        r_rdata <= mem[n_ptr[ADDR_W-1:0]];
    end

    assign o_valid  = r_ovalid;
    assign o_status = r_ostatus;
    assign o_value  = r_ovalue;

    `RSSG_ASSERT_ALWAYS(a_len_cap, i_clk, i_rst_n, r_len <= LEN_W'(SPEC_CAPACITY), "spec length beyond capacity")
    `RSSG_ASSERT_ALWAYS(a_scan_in_spec, i_clk, i_rst_n, r_scan <= r_len, "scan position past spec end")
    `RSSG_ASSERT_NEXT(a_done_result, i_clk, i_rst_n, r_state == S_DONE && out_free, o_valid && o_value == $past(r_cur), "next result not presented")

endmodule

@@ hdl/rssg_num.sv @@
module rssg_num (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rssg_pkg::t_fld_ctl i_ctl,
    input  logic [7:0]         i_char,
    output rssg_pkg::t_fld_res o_res
);
    import rssg_pkg::*;

    localparam logic [32:0] MAG_CAP = 33'h1_0000_0000;

    t_fstate     r_fst, n_fst;
    logic        r_neg, n_neg;
    logic [32:0] r_mag, n_mag;
    logic [4:0]  r_base, n_base;

    logic [6:0]  dig;
    logic [36:0] prod;
    logic [32:0] mag_sat;

    assign dig = digit_of(i_char);

    // Accumulate one digit; the magnitude clamps just above the 32-bit range.
    always_comb begin
        case (r_base)
            5'd8:    prod = 37'({r_mag, 3'b000});
            5'd16:   prod = {r_mag, 4'b0000};
            default: prod = 37'({r_mag, 3'b000}) + 37'({r_mag, 1'b0});
        endcase
        prod = prod + 37'(dig);
        mag_sat = (prod > 37'(MAG_CAP)) ? MAG_CAP : prod[32:0];
    end

    always_comb begin
        n_fst  = r_fst;
        n_neg  = r_neg;
        n_mag  = r_mag;
        n_base = r_base;
        if (i_ctl.clr) begin
            n_fst  = F_EMPTY;
            n_neg  = 1'b0;
            n_mag  = 33'd0;
            n_base = 5'd10;
        end else if (i_ctl.feed) begin
            case (r_fst)
                F_EMPTY: begin
                    if (i_char == CH_PLUS || i_char == CH_MINUS) begin
                        n_fst = F_SIGN;
                        n_neg = (i_char == CH_MINUS);
                    end else if (i_char == CH_ZERO) begin
                        n_fst = F_ZERO;
                    end else if (dig < 7'd10) begin
                        n_fst  = F_DIG;
                        n_base = 5'd10;
                        n_mag  = 33'(dig);
                    end else begin
                        n_fst = F_BAD;
                    end
                end
                F_SIGN: begin
                    if (i_char == CH_ZERO) begin
                        n_fst = F_ZERO;
                    end else if (dig < 7'd10) begin
                        n_fst  = F_DIG;
                        n_base = 5'd10;
                        n_mag  = 33'(dig);
                    end else begin
                        n_fst = F_BAD;
                    end
                end
                F_ZERO: begin
                    if (i_char == CH_LX || i_char == CH_UX) begin
                        n_fst = F_ZX;
                    end else if (dig < 7'd8) begin
                        n_fst  = F_DIG;
                        n_base = 5'd8;
                        n_mag  = 33'(dig);
                    end else begin
                        n_fst = F_BAD;
                    end
                end
                F_ZX: begin
                    if (dig < 7'd16) begin
                        n_fst  = F_DIG;
                        n_base = 5'd16;
                        n_mag  = 33'(dig);
                    end else begin
                        n_fst = F_BAD;
                    end
                end
                F_DIG: begin
                    if (dig < {2'b00, r_base}) begin
                        n_mag = mag_sat;
                    end else begin
                        n_fst = F_BAD;
                    end
                end
                default: n_fst = F_BAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fst <= F_EMPTY;
        end else begin
            r_fst <= n_fst;
        end
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_base <= n_base;
    end

    // A lone zero and a digit run are both complete numbers.
    always_comb begin
        o_res.empty = (r_fst == F_EMPTY);
        o_res.good  = (r_fst == F_ZERO) || (r_fst == F_DIG);
        if (r_fst == F_ZERO) begin
            o_res.num = 32'sd0;
        end else if (r_neg) begin
            o_res.num = (r_mag >= 33'h0_8000_0000) ? 32'sh8000_0000 : -$signed(r_mag[31:0]);
        end else begin
            o_res.num = (r_mag > 33'h0_7fff_ffff) ? 32'sh7fff_ffff : $signed(r_mag[31:0]);
        end
    end

endmodule
